### rtl/core/ssd_pkg.sv
// ============================================================================
// Segment distance package
// Shared widths, payload structs and helpers for the segment-to-segment
// distance pipeline.
// ============================================================================
package ssd_pkg;

    // Coordinate format: two's complement, 12 fractional bits. The integer
    // datapath does not depend on the fraction, so only the width is carried.
    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;   // difference of two coordinates
    localparam int PROD_W     = 2 * DIFF_W;       // product of two differences
    localparam int SUM_W      = PROD_W + 1;       // dot or cross product
    localparam int SQD_W      = 2 * DIFF_W;       // squared length, unsigned
    localparam int MAG_W      = 2 * DIFF_W;       // magnitude of a cross product
    localparam int SQR_W      = 2 * MAG_W;        // cross product squared
    localparam int ROOT_W     = DIFF_W;           // square root of a SQD_W value
    localparam int GAP_W      = 25;
    localparam int NTERM      = 4;                // endpoint-to-segment terms

    localparam logic [GAP_W-1:0] GAP_MAX = '1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } seg_in_t;

    typedef struct packed {
        logic [GAP_W-1:0] gap_length;
        logic             segments_touch;
    } seg_out_t;

    typedef struct packed {
        logic             touch;
        logic [NTERM-1:0] use_quot;
    } ssd_ctrl_t;

    function automatic diff_t sext(input coord_t v);
        return {v[COORD_BITS-1], v};
    endfunction

endpackage

### rtl/core/ssd_geom.sv
// ============================================================================
// Segment distance geometry front end
// Six register stages: differences, products, sums, intersection test and
// clamp selection, then the cross product squared in partial products.
// ============================================================================
module ssd_geom (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         ce,
    input  logic                                         in_valid,
    input  ssd_pkg::seg_in_t                             in_data,
    output logic                                         out_valid,
    output logic [ssd_pkg::NTERM-1:0][ssd_pkg::SQR_W-1:0] sq,
    output logic [1:0][ssd_pkg::SQD_W-1:0]               len2,
    output logic [ssd_pkg::NTERM-1:0][ssd_pkg::SQD_W-1:0] alt,
    output ssd_pkg::ssd_ctrl_t                           ctrl
);
    import ssd_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Stage 1: differences.
    diff_t px [NTERM];
    diff_t py [NTERM];
    diff_t qsx [NTERM];
    diff_t qsy [NTERM];
    diff_t qex [NTERM];
    diff_t qey [NTERM];
    diff_t va_x_reg, va_y_reg, vb_x_reg, vb_y_reg;
    diff_t spx_reg [NTERM];
    diff_t spy_reg [NTERM];
    diff_t epx_reg [NTERM];
    diff_t epy_reg [NTERM];
    logic  v1_reg;

    // Stage 2: products.
    prod_t cra_reg [NTERM];
    prod_t crb_reg [NTERM];
    prod_t dsa_reg [NTERM];
    prod_t dsb_reg [NTERM];
    prod_t dea_reg [NTERM];
    prod_t deb_reg [NTERM];
    prod_t spxx_reg [NTERM];
    prod_t spyy_reg [NTERM];
    prod_t epxx_reg [NTERM];
    prod_t epyy_reg [NTERM];
    prod_t lxx_reg [2];
    prod_t lyy_reg [2];
    logic [NTERM-1:0] box_next, box2_reg;
    logic  v2_reg;

    // Stage 3: sums.
    sum_t cr_reg [NTERM];
    sum_t ds_reg [NTERM];
    sum_t de_reg [NTERM];
    logic [SQD_W-1:0] sp2_reg [NTERM];
    logic [SQD_W-1:0] ep2_reg [NTERM];
    logic [SQD_W-1:0] len3_reg [2];
    logic [NTERM-1:0] box3_reg;
    logic  v3_reg;

    // Stage 4: intersection test, clamp selection, magnitude.
    logic [NTERM-1:0] cr_neg, cr_zero;
    sum_t             cr_abs [NTERM];
    logic             touch_next;
    ssd_ctrl_t        ctrl_next;
    logic [MAG_W-1:0] mag_reg [NTERM];
    logic [SQD_W-1:0] alt4_reg [NTERM];
    logic [SQD_W-1:0] len4_reg [2];
    ssd_ctrl_t        ctrl4_reg;
    logic             v4_reg;

    // Stage 5: partial products.
    logic [SQD_W-1:0] hh_reg [NTERM];
    logic [SQD_W-1:0] hl_reg [NTERM];
    logic [SQD_W-1:0] ll_reg [NTERM];
    logic [SQD_W-1:0] alt5_reg [NTERM];
    logic [SQD_W-1:0] len5_reg [2];
    ssd_ctrl_t        ctrl5_reg;
    logic             v5_reg;

    // Stage 6: recombined square.
    logic [SQR_W-1:0] sq_reg [NTERM];
    logic [SQD_W-1:0] alt6_reg [NTERM];
    logic [SQD_W-1:0] len6_reg [2];
    ssd_ctrl_t        ctrl6_reg;
    logic             v6_reg;

    // Terms in order: B start and B end against A, A start and A end against B.
    always_comb begin
        px[0]  = sext(in_data.b_start_x); py[0]  = sext(in_data.b_start_y);
        px[1]  = sext(in_data.b_end_x);   py[1]  = sext(in_data.b_end_y);
        px[2]  = sext(in_data.a_start_x); py[2]  = sext(in_data.a_start_y);
        px[3]  = sext(in_data.a_end_x);   py[3]  = sext(in_data.a_end_y);
        for (int k = 0; k < NTERM; k++) begin
            if (k < 2) begin
                qsx[k] = sext(in_data.a_start_x); qsy[k] = sext(in_data.a_start_y);
                qex[k] = sext(in_data.a_end_x);   qey[k] = sext(in_data.a_end_y);
            end else begin
                qsx[k] = sext(in_data.b_start_x); qsy[k] = sext(in_data.b_start_y);
                qex[k] = sext(in_data.b_end_x);   qey[k] = sext(in_data.b_end_y);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            va_x_reg <= sext(in_data.a_end_x) - sext(in_data.a_start_x);
            va_y_reg <= sext(in_data.a_end_y) - sext(in_data.a_start_y);
            vb_x_reg <= sext(in_data.b_end_x) - sext(in_data.b_start_x);
            vb_y_reg <= sext(in_data.b_end_y) - sext(in_data.b_start_y);
            for (int k = 0; k < NTERM; k++) begin
                spx_reg[k] <= px[k] - qsx[k];
                spy_reg[k] <= py[k] - qsy[k];
                epx_reg[k] <= px[k] - qex[k];
                epy_reg[k] <= py[k] - qey[k];
            end
        end
    end

    // A point lies in the box of a segment when, on each axis, its offsets
    // from the two ends do not share a strict sign.
    always_comb begin
        for (int k = 0; k < NTERM; k++) begin
            box_next[k] =
                !((!spx_reg[k][DIFF_W-1] && spx_reg[k] != '0 &&
                   !epx_reg[k][DIFF_W-1] && epx_reg[k] != '0) ||
                  (spx_reg[k][DIFF_W-1] && epx_reg[k][DIFF_W-1])) &&
                !((!spy_reg[k][DIFF_W-1] && spy_reg[k] != '0 &&
                   !epy_reg[k][DIFF_W-1] && epy_reg[k] != '0) ||
                  (spy_reg[k][DIFF_W-1] && epy_reg[k][DIFF_W-1]));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NTERM; k++) begin
                if (k < 2) begin
                    cra_reg[k] <= spx_reg[k] * va_y_reg;
                    crb_reg[k] <= spy_reg[k] * va_x_reg;
                    dsa_reg[k] <= va_x_reg * spx_reg[k];
                    dsb_reg[k] <= va_y_reg * spy_reg[k];
                    dea_reg[k] <= va_x_reg * epx_reg[k];
                    deb_reg[k] <= va_y_reg * epy_reg[k];
                end else begin
                    cra_reg[k] <= spx_reg[k] * vb_y_reg;
                    crb_reg[k] <= spy_reg[k] * vb_x_reg;
                    dsa_reg[k] <= vb_x_reg * spx_reg[k];
                    dsb_reg[k] <= vb_y_reg * spy_reg[k];
                    dea_reg[k] <= vb_x_reg * epx_reg[k];
                    deb_reg[k] <= vb_y_reg * epy_reg[k];
                end
                spxx_reg[k] <= spx_reg[k] * spx_reg[k];
                spyy_reg[k] <= spy_reg[k] * spy_reg[k];
                epxx_reg[k] <= epx_reg[k] * epx_reg[k];
                epyy_reg[k] <= epy_reg[k] * epy_reg[k];
            end
            lxx_reg[0] <= va_x_reg * va_x_reg;
            lyy_reg[0] <= va_y_reg * va_y_reg;
            lxx_reg[1] <= vb_x_reg * vb_x_reg;
            lyy_reg[1] <= vb_y_reg * vb_y_reg;
            box2_reg   <= box_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NTERM; k++) begin
                cr_reg[k]  <= sum_t'(cra_reg[k]) - sum_t'(crb_reg[k]);
                ds_reg[k]  <= sum_t'(dsa_reg[k]) + sum_t'(dsb_reg[k]);
                de_reg[k]  <= sum_t'(dea_reg[k]) + sum_t'(deb_reg[k]);
                sp2_reg[k] <= $unsigned(spxx_reg[k]) + $unsigned(spyy_reg[k]);
                ep2_reg[k] <= $unsigned(epxx_reg[k]) + $unsigned(epyy_reg[k]);
            end
            for (int s = 0; s < 2; s++) begin
                len3_reg[s] <= $unsigned(lxx_reg[s]) + $unsigned(lyy_reg[s]);
            end
            box3_reg <= box2_reg;
        end
    end

    // The four cross products are, up to sign, the orientation tests of the
    // intersection check.
    always_comb begin
        for (int k = 0; k < NTERM; k++) begin
            cr_neg[k]  = cr_reg[k][SUM_W-1];
            cr_zero[k] = (cr_reg[k] == '0);
            cr_abs[k]  = cr_neg[k] ? -cr_reg[k] : cr_reg[k];
        end
        touch_next = (!cr_zero[0] && !cr_zero[1] && (cr_neg[0] != cr_neg[1]) &&
                      !cr_zero[2] && !cr_zero[3] && (cr_neg[2] != cr_neg[3])) ||
                     (|(cr_zero & box3_reg));
        ctrl_next.touch = touch_next;
        for (int k = 0; k < NTERM; k++) begin
            ctrl_next.use_quot[k] = !(ds_reg[k][SUM_W-1] || ds_reg[k] == '0) &&
                                    de_reg[k][SUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NTERM; k++) begin
                mag_reg[k]  <= cr_abs[k][MAG_W-1:0];
                alt4_reg[k] <= (ds_reg[k][SUM_W-1] || ds_reg[k] == '0) ?
                               sp2_reg[k] : ep2_reg[k];
            end
            len4_reg  <= len3_reg;
            ctrl4_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NTERM; k++) begin
                hh_reg[k] <= mag_reg[k][MAG_W-1:DIFF_W] * mag_reg[k][MAG_W-1:DIFF_W];
                hl_reg[k] <= mag_reg[k][MAG_W-1:DIFF_W] * mag_reg[k][DIFF_W-1:0];
                ll_reg[k] <= mag_reg[k][DIFF_W-1:0] * mag_reg[k][DIFF_W-1:0];
            end
            alt5_reg  <= alt4_reg;
            len5_reg  <= len4_reg;
            ctrl5_reg <= ctrl4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NTERM; k++) begin
                sq_reg[k] <= {hh_reg[k], {SQD_W{1'b0}}} +
                             {{(DIFF_W-1){1'b0}}, hl_reg[k], {(DIFF_W+1){1'b0}}} +
                             {{SQD_W{1'b0}}, ll_reg[k]};
            end
            alt6_reg  <= alt5_reg;
            len6_reg  <= len5_reg;
            ctrl6_reg <= ctrl5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NTERM; k++) begin
            sq[k]  = sq_reg[k];
            alt[k] = alt6_reg[k];
        end
        len2[0] = len6_reg[0];
        len2[1] = len6_reg[1];
    end

    assign ctrl      = ctrl6_reg;
    assign out_valid = v6_reg;

endmodule

### rtl/core/ssd_div.sv
// ============================================================================
// Segment distance pipelined divider
// Restoring division, one quotient bit per register stage, with a sideband
// that travels alongside the operands.
// ============================================================================
module ssd_div #(
    parameter int DVW = ssd_pkg::SQD_W,
    parameter int SW  = ssd_pkg::SQD_W + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  logic [2*DVW-1:0] dividend,
    input  logic [DVW-1:0]   divisor,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [DVW-1:0]   quotient,
    output logic [SW-1:0]    side_out
);
    // The quotient is only used where it is known to fit in DVW bits, so the
    // upper half of the dividend starts out as the partial remainder.
    logic [DVW-1:0] rem_reg  [DVW];
    logic [DVW-1:0] low_reg  [DVW];
    logic [DVW-1:0] quo_reg  [DVW];
    logic [DVW-1:0] den_reg  [DVW];
    logic [SW-1:0]  side_reg [DVW];
    logic           valid_reg [DVW];

    for (genvar g = 0; g < DVW; g++) begin : g_stage
        logic [DVW-1:0] rem_in, low_in, quo_in, den_in;
        logic [SW-1:0]  side_w;
        logic           valid_w;
        logic [DVW:0]   trial, diff;
        logic           take;

        if (g == 0) begin : g_first
            assign rem_in  = dividend[2*DVW-1:DVW];
            assign low_in  = dividend[DVW-1:0];
            assign quo_in  = '0;
            assign den_in  = divisor;
            assign side_w  = side_in;
            assign valid_w = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign low_in  = low_reg[g-1];
            assign quo_in  = quo_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign side_w  = side_reg[g-1];
            assign valid_w = valid_reg[g-1];
        end

        assign trial = {rem_in, low_in[DVW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[g]  <= take ? diff[DVW-1:0] : trial[DVW-1:0];
                low_reg[g]  <= {low_in[DVW-2:0], 1'b0};
                quo_reg[g]  <= {quo_in[DVW-2:0], take};
                den_reg[g]  <= den_in;
                side_reg[g] <= side_w;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (ce) begin
                valid_reg[g] <= valid_w;
            end
        end
    end

    assign out_valid = valid_reg[DVW-1];
    assign quotient  = quo_reg[DVW-1];
    assign side_out  = side_reg[DVW-1];

endmodule

### rtl/core/ssd_isqrt.sv
// ============================================================================
// Segment distance pipelined square root
// Digit-by-digit floor square root, one root bit per register stage, with a
// sideband that travels alongside.
// ============================================================================
module ssd_isqrt #(
    parameter int RW = ssd_pkg::ROOT_W,
    parameter int SW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  logic [2*RW-1:0] value,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);
    logic [2*RW-1:0] val_reg  [RW];
    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [SW-1:0]   side_reg [RW];
    logic            valid_reg [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [2*RW-1:0] val_in;
        logic [RW:0]     rem_in;
        logic [RW-1:0]   root_in;
        logic [SW-1:0]   side_w;
        logic            valid_w;
        logic [RW+2:0]   trial, cand, diff;
        logic            take;

        if (g == 0) begin : g_first
            assign val_in  = value;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_w  = side_in;
            assign valid_w = in_valid;
        end else begin : g_next
            assign val_in  = val_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_w  = side_reg[g-1];
            assign valid_w = valid_reg[g-1];
        end

        assign trial = {rem_in, val_in[2*RW-1:2*RW-2]};
        assign cand  = {1'b0, root_in, 2'b01};
        assign diff  = trial - cand;
        assign take  = (trial >= cand);

        always_ff @(posedge aclk) begin
            if (ce) begin
                val_reg[g]  <= {val_in[2*RW-3:0], 2'b00};
                rem_reg[g]  <= take ? diff[RW:0] : trial[RW:0];
                root_reg[g] <= {root_in[RW-2:0], take};
                side_reg[g] <= side_w;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (ce) begin
                valid_reg[g] <= valid_w;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

### rtl/core/segment_segment_distance.sv
// ============================================================================
// Segment-to-segment distance
// Shortest distance between two 2D segments, one pair per unstalled clock.
// ============================================================================
// Each input transaction on s_valid/s_ready carries two segments as eight
// signed coordinates with 12 fractional bits. Each output transaction on
// m_valid/m_ready carries the floored distance gap_length (same fraction) and
// segments_touch, which is set, with the distance forced to zero, when the
// segments cross, touch, overlap or share an endpoint.
// From acceptance to m_valid the pipeline has 6 geometry stages, 50
// divider stages (one quotient bit of cross^2 / length^2 each), 2 stages of
// minimum selection, 25 square root stages (one root bit each) and the output
// register. One transaction is taken per cycle while the skid register is
// empty; the divider and square root are fully pipelined, one bit per stage.
// Reset clears every valid bit in the pipeline and both output registers;
// no result is pending afterwards and s_ready rises with the reset release.
// When the receiver stalls, a finished result is parked in a skid register
// and the pipeline freezes only once that register is full; s_ready comes
// from the skid flop and the reset input only, and does not depend on m_ready.
// ============================================================================
module segment_segment_distance (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssd_pkg::seg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssd_pkg::seg_out_t m_data
);
    import ssd_pkg::*;

    localparam int SIDE_W = SQD_W + 2;
    localparam int WX     = (ROOT_W > GAP_W) ? ROOT_W : GAP_W;

    // The whole pipeline advances together unless the skid register holds a
    // result that could not be handed over.
    logic ce;

    logic                        geo_valid;
    logic [NTERM-1:0][SQR_W-1:0] geo_sq;
    logic [1:0][SQD_W-1:0]       geo_len2;
    logic [NTERM-1:0][SQD_W-1:0] geo_alt;
    ssd_ctrl_t                   geo_ctrl;

    logic [NTERM-1:0]              div_valid;
    logic [NTERM-1:0][SQD_W-1:0]   div_quot;
    logic [NTERM-1:0][SIDE_W-1:0]  div_side;
    logic [NTERM-1:0][SQD_W-1:0]   term_d2;

    logic [SQD_W-1:0] min01_reg, min23_reg, min_reg;
    logic             touch1_reg, touch2_reg;
    logic             vm1_reg, vm2_reg;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_touch;
    logic [WX-1:0]     root_x;
    seg_out_t          pipe_data;

    seg_out_t m_data_reg, skid_data_reg;
    logic     m_valid_reg, skid_valid_reg;

    assign ce      = !skid_valid_reg;
    // No transaction is taken while reset is held, since the valid bits are
    // being cleared in that cycle.
    assign s_ready = ce && aresetn;

    ssd_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (geo_valid),
        .sq        (geo_sq),
        .len2      (geo_len2),
        .alt       (geo_alt),
        .ctrl      (geo_ctrl)
    );

    // One divider per endpoint term; the sideband holds the clamped distance,
    // whether the quotient applies and the touch flag, read from lane 0 only.
    for (genvar k = 0; k < NTERM; k++) begin : g_div
        ssd_div #(
            .DVW (SQD_W),
            .SW  (SIDE_W)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (geo_valid),
            .dividend  (geo_sq[k]),
            .divisor   (geo_len2[k / 2]),
            .side_in   ({geo_ctrl.touch, geo_ctrl.use_quot[k], geo_alt[k]}),
            .out_valid (div_valid[k]),
            .quotient  (div_quot[k]),
            .side_out  (div_side[k])
        );

        assign term_d2[k] = div_side[k][SQD_W] ? div_quot[k] : div_side[k][SQD_W-1:0];
    end

    // Minimum of the four squared distances over two stages.
    always_ff @(posedge aclk) begin
        if (ce) begin
            min01_reg  <= (term_d2[1] < term_d2[0]) ? term_d2[1] : term_d2[0];
            min23_reg  <= (term_d2[3] < term_d2[2]) ? term_d2[3] : term_d2[2];
            touch1_reg <= div_side[0][SIDE_W-1];
            min_reg    <= (min23_reg < min01_reg) ? min23_reg : min01_reg;
            touch2_reg <= touch1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
        end else if (ce) begin
            vm1_reg <= div_valid[0];
            vm2_reg <= vm1_reg;
        end
    end

    ssd_isqrt #(
        .RW (ROOT_W),
        .SW (1)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vm2_reg),
        .value     (min_reg),
        .side_in   (touch2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_touch)
    );

    // Saturate the root to the output width and force zero on contact.
    always_comb begin
        root_x = WX'(sq_root);
        pipe_data.segments_touch = sq_touch;
        if (sq_touch) begin
            pipe_data.gap_length = '0;
        end else if (root_x > WX'(GAP_MAX)) begin
            pipe_data.gap_length = GAP_MAX;
        end else begin
            pipe_data.gap_length = root_x[GAP_W-1:0];
        end
    end

    // Output register with a one-entry skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= sq_valid;
                end
            end else if (sq_valid && ce) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end
        if (ce) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
